// ===== rtl/lcg_mixed_keystream_xor_cipher_assert.svh =====
// Assertion macros for the LCG keystream cipher checker.
// Included by the checker file only; needs nothing else.
`ifndef LCG_MIXED_KEYSTREAM_XOR_CIPHER_ASSERT_SVH
`define LCG_MIXED_KEYSTREAM_XOR_CIPHER_ASSERT_SVH

// consequent in the cycle after the antecedent
`define LCGX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcgx: next-cycle check failed");

// consequent in the same cycle as the antecedent
`define LCGX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcgx: same-cycle check failed");

`endif

// ===== rtl/lcgx_pkg.sv =====
// Shared types, constants and mixing schedule of the LCG keystream cipher.
// Used by the interfaces, the remainder unit and the top level.
`default_nettype none

package lcgx_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned MOD_W  = 31;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned STEP_W = 5;
  localparam int unsigned SHAMT_W = 5;
  localparam int unsigned POS_W  = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_SEED       = 3'd1;
  localparam logic [IDX_W-1:0] REG_MULTIPLIER = 3'd2;
  localparam logic [IDX_W-1:0] REG_INCREMENT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MODULUS    = 3'd4;

  localparam logic              MODE_V3 = 1'b0;
  localparam logic              MODE_V4 = 1'b1;

  localparam logic [WORD_W-1:0] SEED_RST  = 32'd2885;
  localparam logic [WORD_W-1:0] MULT_RST  = 32'd1103515245;
  localparam logic [WORD_W-1:0] INCR_RST  = 32'd12345;
  localparam logic [MOD_W-1:0]  MOD_RST   = 31'h7FFF_FFFF;

  // generator draws per mixing run
  localparam int unsigned V3_DRAWS = 26;
  localparam int unsigned V4_DRAWS = 8;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_LEFT,
    SH_ASR
  } shift_e;

  // one step of the schedule: t = post(rep ? pre(v) : t ^ pre(v))
  typedef struct packed {
    logic               rep;
    shift_e             v_kind;
    logic [SHAMT_W-1:0] v_amt;
    shift_e             p_kind;
    logic [SHAMT_W-1:0] p_amt;
  } mix_op_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [MOD_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } rem_rsp_t;

  function automatic logic [WORD_W-1:0] shift_word(input logic [WORD_W-1:0] x,
                                                   input shift_e kind,
                                                   input logic [SHAMT_W-1:0] amt);
    logic [WORD_W-1:0] r;
    case (kind)
      SH_LEFT: r = x << amt;
      SH_ASR:  r = WORD_W'($signed(x) >>> amt);
      default: r = x;
    endcase
    return r;
  endfunction

  function automatic mix_op_t mk_op(input logic rep, input shift_e vk,
                                    input logic [SHAMT_W-1:0] va, input shift_e pk,
                                    input logic [SHAMT_W-1:0] pa);
    mix_op_t o;
    o.rep    = rep;
    o.v_kind = vk;
    o.v_amt  = va;
    o.p_kind = pk;
    o.p_amt  = pa;
    return o;
  endfunction

  // per-byte schedule, 26 draws
  function automatic mix_op_t v3_op(input logic [STEP_W-1:0] idx);
    mix_op_t o;
    case (idx)
      5'd0:    o = mk_op(1'b1, SH_NONE, 5'd0,  SH_NONE, 5'd0);
      5'd1:    o = mk_op(1'b0, SH_LEFT, 5'd18, SH_NONE, 5'd0);
      5'd2:    o = mk_op(1'b0, SH_LEFT, 5'd2,  SH_NONE, 5'd0);
      5'd3:    o = mk_op(1'b0, SH_NONE, 5'd0,  SH_NONE, 5'd0);
      5'd4:    o = mk_op(1'b1, SH_NONE, 5'd0,  SH_NONE, 5'd0);
      5'd5:    o = mk_op(1'b0, SH_NONE, 5'd0,  SH_LEFT, 5'd7);
      5'd6:    o = mk_op(1'b0, SH_NONE, 5'd0,  SH_ASR,  5'd3);
      5'd7:    o = mk_op(1'b0, SH_NONE, 5'd0,  SH_LEFT, 5'd8);
      5'd8:    o = mk_op(1'b0, SH_NONE, 5'd0,  SH_ASR,  5'd5);
      5'd9:    o = mk_op(1'b0, SH_NONE, 5'd0,  SH_LEFT, 5'd10);
      5'd10:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_ASR,  5'd2);
      5'd11:   o = mk_op(1'b0, SH_LEFT, 5'd18, SH_NONE, 5'd0);
      5'd12:   o = mk_op(1'b0, SH_LEFT, 5'd2,  SH_NONE, 5'd0);
      5'd13:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_NONE, 5'd0);
      5'd14:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_LEFT, 5'd12);
      5'd15:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_ASR,  5'd4);
      5'd16:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_LEFT, 5'd6);
      5'd17:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_ASR,  5'd8);
      5'd18:   o = mk_op(1'b0, SH_LEFT, 5'd18, SH_LEFT, 5'd9);
      5'd19:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_ASR,  5'd3);
      5'd20:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_LEFT, 5'd6);
      5'd21:   o = mk_op(1'b0, SH_NONE, 5'd0,  SH_ASR,  5'd8);
      5'd22:   o = mk_op(1'b0, SH_LEFT, 5'd18, SH_NONE, 5'd0);
      5'd23:   o = mk_op(1'b0, SH_LEFT, 5'd17, SH_NONE, 5'd0);
      5'd24:   o = mk_op(1'b0, SH_LEFT, 5'd17, SH_NONE, 5'd0);
      default: o = mk_op(1'b0, SH_NONE, 5'd0,  SH_NONE, 5'd0);
    endcase
    return o;
  endfunction

  // per-word schedule, 8 draws
  function automatic mix_op_t v4_op(input logic [2:0] idx);
    mix_op_t o;
    case (idx)
      3'd0:    o = mk_op(1'b1, SH_NONE, 5'd0,  SH_LEFT, 5'd9);
      3'd1:    o = mk_op(1'b0, SH_ASR,  5'd12, SH_LEFT, 5'd7);
      3'd2:    o = mk_op(1'b0, SH_ASR,  5'd3,  SH_LEFT, 5'd4);
      3'd3:    o = mk_op(1'b0, SH_ASR,  5'd8,  SH_LEFT, 5'd3);
      3'd4:    o = mk_op(1'b0, SH_ASR,  5'd6,  SH_LEFT, 5'd16);
      3'd5:    o = mk_op(1'b0, SH_ASR,  5'd12, SH_LEFT, 5'd5);
      3'd6:    o = mk_op(1'b0, SH_ASR,  5'd11, SH_LEFT, 5'd9);
      default: o = mk_op(1'b0, SH_ASR,  5'd7,  SH_NONE, 5'd0);
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcgx_if.sv =====
// Valid/ready channel interfaces for the cipher's input and result bytes.
// Depends on lcgx_pkg for the byte width.
`default_nettype none

interface lcgx_in_if;
  logic                          valid;
  logic                          ready;
  logic [lcgx_pkg::DATA_W-1:0]   data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lcgx_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcgx_pkg::DATA_W-1:0]   out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcgx_rem.sv =====
// Bit-serial restoring remainder unit: unsigned dividend modulo a 31-bit divisor.
// One quotient bit per cycle; depends on lcgx_pkg.
`default_nettype none

module lcgx_rem (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lcgx_pkg::rem_req_t req_i,
  output lcgx_pkg::rem_rsp_t      rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [lcgx_pkg::STEP_W-1:0]   cnt_q, cnt_d;
  logic [lcgx_pkg::WORD_W-1:0]   dvd_q, dvd_d;
  logic [lcgx_pkg::MOD_W-1:0]    rem_q, rem_d;
  logic [lcgx_pkg::WORD_W-1:0]   trial;
  logic [lcgx_pkg::WORD_W-1:0]   div_ext;

  assign trial   = {rem_q, dvd_q[lcgx_pkg::WORD_W-1]};
  assign div_ext = {1'b0, req_i.divisor};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
    end else if (busy_q) begin
      // partial remainder stays below the divisor, so the top bit drops out
      if (trial >= div_ext) begin
        rem_d = lcgx_pkg::MOD_W'(trial - div_ext);
      end else begin
        rem_d = trial[lcgx_pkg::MOD_W-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/lcg_mixed_keystream_xor_cipher.sv =====
// XOR byte cipher keyed by a 32-bit LCG, r = (A*r + B) rem M with signed remainder.
// Each generator draw runs a 32x32 multiply-add, loads the bit-serial remainder unit,
// waits for the remainder and then mixes; with a zero modulus the remainder steps are
// skipped. Per-byte mode (mode 0) spends 26 draws per byte. Per-word mode (mode 1)
// spends 8 draws on every fourth byte and none on the other three. One item is in
// work at a time; the result register lets the next request in while a result waits.
// Depends on lcgx_pkg, lcgx_if and lcgx_rem.
`default_nettype none

module lcg_mixed_keystream_xor_cipher (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lcgx_in_if.sink                            data_i,
  lcgx_out_if.source                         result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lcgx_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lcgx_pkg::WORD_W-1:0]   cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MIX  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic                          mode_q;
  logic [lcgx_pkg::WORD_W-1:0]   mult_q, incr_q;
  logic [lcgx_pkg::MOD_W-1:0]    mod_q;
  logic [lcgx_pkg::WORD_W-1:0]   gen_q, key_q;
  logic [lcgx_pkg::POS_W-1:0]    pos_q;
  logic [lcgx_pkg::STEP_W-1:0]   step_q;
  logic [lcgx_pkg::WORD_W-1:0]   prod_q, acc_q;
  logic [lcgx_pkg::DATA_W-1:0]   data_q;
  logic                          out_valid_q;
  logic [lcgx_pkg::DATA_W-1:0]   out_byte_q;

  lcgx_pkg::rem_req_t            rem_req;
  lcgx_pkg::rem_rsp_t            rem_rsp;
  lcgx_pkg::mix_op_t             op;
  logic [lcgx_pkg::WORD_W-1:0]   draw, pre_v, mixed, acc_new;
  logic [lcgx_pkg::DATA_W-1:0]   ks_byte;
  logic                          in_take, out_load, last_draw;

  assign data_i.ready    = (state_q == S_IDLE);
  assign in_take         = data_i.valid && data_i.ready;
  assign result_o.valid  = out_valid_q;
  assign result_o.out_byte = out_byte_q;

  // remainder of |prod|; sign restored at mix time
  assign rem_req.start    = (state_q == S_LOAD);
  assign rem_req.dividend = prod_q[lcgx_pkg::WORD_W-1] ? (32'd0 - prod_q) : prod_q;
  assign rem_req.divisor  = mod_q;

  lcgx_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  always_comb begin
    if (mod_q == '0) begin
      draw = prod_q;
    end else if (prod_q[lcgx_pkg::WORD_W-1]) begin
      draw = 32'd0 - {1'b0, rem_rsp.rem};
    end else begin
      draw = {1'b0, rem_rsp.rem};
    end
    op      = (mode_q == lcgx_pkg::MODE_V4) ? lcgx_pkg::v4_op(step_q[2:0])
                                            : lcgx_pkg::v3_op(step_q);
    pre_v   = lcgx_pkg::shift_word(draw, op.v_kind, op.v_amt);
    mixed   = op.rep ? pre_v : (acc_q ^ pre_v);
    acc_new = lcgx_pkg::shift_word(mixed, op.p_kind, op.p_amt);
    last_draw = (mode_q == lcgx_pkg::MODE_V4)
              ? (step_q == lcgx_pkg::STEP_W'(lcgx_pkg::V4_DRAWS - 1))
              : (step_q == lcgx_pkg::STEP_W'(lcgx_pkg::V3_DRAWS - 1));
  end

  // key word bytes go out most significant first
  always_comb begin
    if (mode_q == lcgx_pkg::MODE_V4) begin
      case (pos_q)
        2'd0:    ks_byte = key_q[31:24];
        2'd1:    ks_byte = key_q[23:16];
        2'd2:    ks_byte = key_q[15:8];
        default: ks_byte = key_q[7:0];
      endcase
    end else begin
      ks_byte = acc_q[lcgx_pkg::DATA_W-1:0];
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (mode_q == lcgx_pkg::MODE_V3 || pos_q == '0) begin
            state_d = S_MUL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL:  state_d = (mod_q == '0) ? S_MIX : S_LOAD;
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (rem_rsp.done) begin
          state_d = S_MIX;
        end
      end
      S_MIX:  state_d = last_draw ? S_DONE : S_MUL;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= lcgx_pkg::MODE_V4;
      mult_q      <= lcgx_pkg::MULT_RST;
      incr_q      <= lcgx_pkg::INCR_RST;
      mod_q       <= lcgx_pkg::MOD_RST;
      gen_q       <= lcgx_pkg::SEED_RST;
      key_q       <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_take) begin
        step_q <= '0;
      end
      if (state_q == S_MIX) begin
        step_q <= step_q + 1'b1;
        if (last_draw && mode_q == lcgx_pkg::MODE_V4) begin
          // mixed word replaces the generator state
          gen_q <= acc_new;
          key_q <= acc_new;
        end else begin
          gen_q <= draw;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        if (mode_q == lcgx_pkg::MODE_V4) begin
          pos_q <= pos_q + 1'b1;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          lcgx_pkg::REG_MODE:       mode_q <= cfg_data_i[0];
          lcgx_pkg::REG_SEED: begin
            gen_q <= cfg_data_i;
            pos_q <= '0;
          end
          lcgx_pkg::REG_MULTIPLIER: mult_q <= cfg_data_i;
          lcgx_pkg::REG_INCREMENT:  incr_q <= cfg_data_i;
          lcgx_pkg::REG_MODULUS:    mod_q  <= cfg_data_i[lcgx_pkg::MOD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q <= data_i.data_byte;
    end
    if (state_q == S_MUL) begin
      prod_q <= lcgx_pkg::WORD_W'(mult_q * gen_q) + incr_q;
    end
    if (state_q == S_MIX) begin
      acc_q <= acc_new;
    end
    if (out_load) begin
      out_byte_q <= data_q ^ ks_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcgx_checker.sv =====
// Port-level checks for the LCG keystream cipher, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "lcg_mixed_keystream_xor_cipher_assert.svh"

module lcgx_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [lcgx_pkg::DATA_W-1:0] out_byte_i
);

  // one request in work at a time
  `LCGX_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // a fresh result only appears as the block frees up
  `LCGX_ASSERT_NOW(a_result_frees, clk_i, rst_ni, $rose(out_valid_i), in_ready_i)
  `LCGX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `LCGX_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_byte_i))

endmodule

bind lcg_mixed_keystream_xor_cipher lcgx_checker u_lcgx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (data_i.valid),
  .in_ready_i  (data_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_byte_i  (result_o.out_byte)
);

`default_nettype wire

// ===== test/tb_lcg_mixed_keystream_xor_cipher.sv =====
// Self-checking bench for the LCG keystream XOR cipher: a directed table, then random phases.
// Expected bytes come from a behavioural model of the generator held in the bench.
// Depends on lcgx_pkg, lcgx_if and the cipher top level.

module tb_lcg_mixed_keystream_xor_cipher;
  import lcgx_pkg::*;

  localparam int unsigned KEY_BYTES   = 4;
  localparam int unsigned RAND_ITEMS  = 580;
  localparam int unsigned HOLD_CYCLES = 2500;
  localparam int unsigned CYCLE_LIMIT = 2_500_000;
  localparam int unsigned PLAN_LEN    = 39;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = REG_MODULUS + 1'b1;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = '1;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] value;   // register data, or the request byte
    bit                typed;   // result written into the row
    logic [DATA_W-1:0] result;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_idx;
  logic [WORD_W-1:0] cfg_data;

  lcgx_in_if  in_ch ();
  lcgx_out_if res_ch ();

  lcg_mixed_keystream_xor_cipher uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_i     (in_ch),
    .result_o   (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // generator model state and its copy of the registers
  logic              mode_r     = MODE_V4;
  logic [WORD_W-1:0] mult_r     = MULT_RST;
  logic [WORD_W-1:0] incr_r     = INCR_RST;
  logic [MOD_W-1:0]  mod_r      = MOD_RST;
  logic [WORD_W-1:0] key_gen_q  = SEED_RST;
  logic [WORD_W-1:0] key_word_q = '0;
  logic [1:0]        key_pos_q  = '0;

  logic [DATA_W-1:0] cipher_q [$];
  int unsigned       mismatch_cnt = 0;
  bit                src_idle_on  = 1'b1;
  bit                sink_idle_on = 1'b1;
  bit                hold_req     = 1'b0;
  row_t              plan [PLAN_LEN];

  function automatic logic [WORD_W-1:0] sign_shr(input logic [WORD_W-1:0] x,
                                                 input int unsigned s);
    return x[WORD_W-1] ? ~((~x) >> s) : x >> s;
  endfunction

  // remainder truncates toward zero, so it follows the sign of the wrapped sum
  function automatic logic [WORD_W-1:0] lcg_draw();
    logic [WORD_W-1:0] t, mag, rem;
    t = mult_r * key_gen_q + incr_r;
    if (mod_r != '0) begin
      mag = t[WORD_W-1] ? -t : t;
      rem = mag % {1'b0, mod_r};
      t   = t[WORD_W-1] ? -rem : rem;
    end
    key_gen_q = t;
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] mix_byte_key();
    logic [WORD_W-1:0] t;
    t = lcg_draw();
    t ^= lcg_draw() << 18;
    t ^= lcg_draw() << 2;
    t ^= lcg_draw();

    t = lcg_draw();
    t ^= lcg_draw();
    t = t << 7;
    t ^= lcg_draw();  t = sign_shr(t, 3);
    t ^= lcg_draw();  t = t << 8;
    t ^= lcg_draw();  t = sign_shr(t, 5);
    t ^= lcg_draw();  t = t << 10;
    t ^= lcg_draw();  t = sign_shr(t, 2);

    t ^= lcg_draw() << 18;
    t ^= lcg_draw() << 2;
    t ^= lcg_draw();

    t ^= lcg_draw();  t = t << 12;
    t ^= lcg_draw();  t = sign_shr(t, 4);
    t ^= lcg_draw();  t = t << 6;
    t ^= lcg_draw();  t = sign_shr(t, 8);
    t ^= lcg_draw() << 18;
    t = t << 9;
    t ^= lcg_draw();  t = sign_shr(t, 3);
    t ^= lcg_draw();  t = t << 6;
    t ^= lcg_draw();  t = sign_shr(t, 8);
    t ^= lcg_draw() << 18;

    t ^= lcg_draw() << 17;
    t ^= lcg_draw() << 17;
    t ^= lcg_draw();
    return t;
  endfunction

  // mixed word also becomes the generator state
  function automatic logic [WORD_W-1:0] mix_word_key();
    logic [WORD_W-1:0] t;
    t = lcg_draw();
    t = t << 9;  t ^= sign_shr(lcg_draw(), 12);
    t = t << 7;  t ^= sign_shr(lcg_draw(), 3);
    t = t << 4;  t ^= sign_shr(lcg_draw(), 8);
    t = t << 3;  t ^= sign_shr(lcg_draw(), 6);
    t = t << 16; t ^= sign_shr(lcg_draw(), 12);
    t = t << 5;  t ^= sign_shr(lcg_draw(), 11);
    t = t << 9;  t ^= sign_shr(lcg_draw(), 7);
    key_gen_q = t;
    return t;
  endfunction

  function automatic logic [DATA_W-1:0] cipher_byte(input logic [DATA_W-1:0] d);
    logic [WORD_W-1:0] w;
    if (mode_r == MODE_V3) begin
      w = mix_byte_key();
    end else begin
      if (key_pos_q == 2'd0) key_word_q = mix_word_key();
      w = key_word_q >> (8 * (KEY_BYTES - 1 - int'(key_pos_q)));
      key_pos_q = key_pos_q + 2'd1;
    end
    return d ^ w[DATA_W-1:0];
  endfunction

  function automatic row_t wr(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    row_t r;
    r = '{ROW_WRITE, idx, val, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t by(input logic [DATA_W-1:0] d);
    row_t r;
    r = '{ROW_BYTE, REG_MODE, WORD_W'(d), 1'b0, '0};
    return r;
  endfunction

  function automatic row_t byx(input logic [DATA_W-1:0] d, input logic [DATA_W-1:0] res);
    row_t r;
    r = '{ROW_BYTE, REG_MODE, WORD_W'(d), 1'b1, res};
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: %s: got %02h, expected %02h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    case (idx)
      REG_MODE:       mode_r = val[0];
      REG_SEED:       begin key_gen_q = val; key_pos_q = '0; end
      REG_MULTIPLIER: mult_r = val;
      REG_INCREMENT:  incr_r = val;
      REG_MODULUS:    mod_r  = val[MOD_W-1:0];
      default:        ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    in_ch.valid = 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // entered and left at a falling edge; valid stays high on exit
  task automatic offer_byte(input logic [DATA_W-1:0] d, input bit typed,
                            input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] res;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid     = 1'b0;
      in_ch.data_byte = DATA_W'($urandom());
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = d;
    do @(posedge clk_i); while (!in_ch.ready);
    res = cipher_byte(d);
    cipher_q.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    logic [DATA_W-1:0] want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("result with no request pending", res_ch.out_byte, 'x);
      end else begin
        want = cipher_q.pop_front();
        if (res_ch.out_byte !== want)
          report_mismatch("out_byte", res_ch.out_byte, want);
      end
    end
  end

  initial begin : result_sink
    int unsigned held;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_ch.ready = 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      res_ch.ready = 1'b1;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent, n, i, pause_at, phase;
    logic [WORD_W-1:0] val;

    plan = '{
      by(8'h00), by(8'hFF), by(8'h55), by(8'hAA), by(8'h01),
      wr(REG_MODE, WORD_W'(MODE_V3)),           // switch with one byte of the word used
      by(8'h80), by(8'h7F),
      wr(REG_MODE, WORD_W'(MODE_V4)),           // picks up the same word again
      by(8'h0F),
      wr(REG_SEED, 32'h8000_0000),
      by(8'hF0),
      wr(REG_MODULUS, 32'd1),                   // every draw is zero from here
      wr(REG_SEED, 32'd0),
      byx(8'h3C, 8'h3C), byx(8'hC3, 8'hC3),
      wr(REG_MODE, WORD_W'(MODE_V3)),
      byx(8'h5A, 8'h5A),
      wr(REG_MODULUS, 32'd0),                   // no remainder at all
      wr(REG_MULTIPLIER, 32'hFFFF_FFFF),
      wr(REG_INCREMENT, 32'h8000_0000),
      by(8'h12),
      wr(REG_MODE, WORD_W'(MODE_V4)),
      by(8'h34), by(8'h56),
      wr(REG_MODULUS, 32'hFFFF_FFFF),           // top bit dropped by the register
      wr(REG_MULTIPLIER, 32'h7FFF_FFFF),
      wr(REG_INCREMENT, 32'h7FFF_FFFF),
      wr(REG_SEED, 32'h7FFF_FFFF),
      by(8'h00), by(8'hFF),
      wr(REG_SPARE_HI, 32'hFFFF_FFFF),
      by(8'h99),
      wr(REG_MODE, WORD_W'(MODE_V3)),
      by(8'hA5),
      wr(REG_MULTIPLIER, 32'd0),
      wr(REG_INCREMENT, 32'd0),
      wr(REG_SEED, 32'hFFFF_FFFF),
      byx(8'h66, 8'h66)
    };

    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[r].idx, plan[r].value);
      end else begin
        offer_byte(plan[r].value[DATA_W-1:0], plan[r].typed, plan[r].result);
      end
    end

    sent = 0;
    for (phase = 0; sent < RAND_ITEMS; phase++) begin
      settle();
      src_idle_on  = (sent + 80 < RAND_ITEMS) && $urandom_range(0, 3) != 0;
      sink_idle_on = (sent + 80 < RAND_ITEMS) && $urandom_range(0, 3) != 0;

      if ($urandom_range(0, 3) != 0) begin
        val    = $urandom();
        val[0] = ($urandom_range(0, 2) == 0) ? MODE_V3 : MODE_V4;
        write_reg(REG_MODE, val);
      end
      if ($urandom_range(0, 1) != 0) write_reg(REG_MULTIPLIER, pick_word());
      if ($urandom_range(0, 1) != 0) write_reg(REG_INCREMENT, pick_word());
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 5))
          0:       val = '0;
          1:       val = 32'd1;
          2:       val = 32'h7FFF_FFFF;
          3:       val = $urandom_range(2, 255);
          4:       val = $urandom() | 32'h8000_0000;
          default: val = $urandom();
        endcase
        write_reg(REG_MODULUS, val);
      end
      if ($urandom_range(0, 1) != 0) write_reg(REG_SEED, pick_word());
      if ($urandom_range(0, 5) == 0)
        write_reg(IDX_W'($urandom_range(int'(REG_SPARE_LO), int'(REG_SPARE_HI))),
                  $urandom());

      // result side stalls for a long stretch while requests keep coming
      if (phase == 3) hold_req = 1'b1;

      n = $urandom_range(16, 40);
      if (n > RAND_ITEMS - sent) n = RAND_ITEMS - sent;
      pause_at = (n > 2 && (phase == 1 || $urandom_range(0, 3) == 0)) ?
                 $urandom_range(1, n - 1) : n;
      for (i = 0; i < n; i++) begin
        if (i == pause_at) settle();
        offer_byte(DATA_W'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end
    end

    settle();
    repeat (1000) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
